FILE: rtl/core/brpt_pkg.sv
// Shared types for the byte range position table.
// Holds the item function codes, the controller states and the stored entry layout.
// No dependencies.
package brpt_pkg;

  localparam int unsigned OfsW = 24;
  localparam int unsigned RowW = 20;
  localparam int unsigned ColW = 16;

  typedef enum logic [1:0] {
    FUNC_ADD       = 2'd0,
    FUNC_ADD_AFTER = 2'd1,
    FUNC_LOOKUP    = 2'd2
  } brpt_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } brpt_state_e;

  typedef struct packed {
    logic [OfsW-1:0] first;
    logic [OfsW-1:0] past;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } brpt_entry_t;

  typedef struct packed {
    logic        wr_en;
    brpt_entry_t wr_data;
    logic        rd_en;
  } brpt_mem_ctrl_t;

endpackage

FILE: rtl/core/byte_range_position_table.sv
// Byte range position table: an add item appends an entry unless the table is full, and
// its result is ready the cycle after; a lookup item scans the entries in insertion order,
// one entry per cycle through the single read port of the entry memory, and ends on
// the first hit. One item is in work at a time. The entry memory needs no clearing pass
// after reset: only entries below the fill count are read.
module byte_range_position_table #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [23:0] range_start_i,
  input  logic [23:0] range_end_i,
  input  logic [23:0] range_length_i,
  input  logic [19:0] source_row_i,
  input  logic [15:0] source_column_i,
  input  logic [23:0] query_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [19:0] found_row_o,
  output logic [15:0] found_column_o,
  output logic        table_full_o
);

  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned OfsW  = brpt_pkg::OfsW;
  localparam int unsigned RowW  = brpt_pkg::RowW;
  localparam int unsigned ColW  = brpt_pkg::ColW;
  localparam logic [CntW-1:0] FillMax = CntW'(MAX_ENTRIES);

  brpt_pkg::brpt_state_e state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] issue_cnt_q, issue_cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            cmp_last_q, cmp_last_d;
  logic [OfsW-1:0] last_past_q, last_past_d;
  logic [OfsW-1:0] query_q, query_d;
  logic            res_found_q, res_found_d;
  logic [RowW-1:0] res_row_q, res_row_d;
  logic [ColW-1:0] res_col_q, res_col_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            full_q, full_d;

  brpt_pkg::brpt_mem_ctrl_t mem_ctrl;
  brpt_pkg::brpt_entry_t    rd_data;
  logic [AddrW-1:0]         rd_addr;
  logic                     accept;
  logic                     tbl_full;
  logic                     hit;
  logic [OfsW:0]            sum;

  brpt_entry_mem #(
    .Depth (MAX_ENTRIES),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .ctrl_i    (mem_ctrl),
    .wr_addr_i (fill_q[AddrW-1:0]),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = (state_q == brpt_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign tbl_full   = (fill_q == FillMax);
  assign hit        = (rd_data.first <= query_q) && (query_q < rd_data.past);
  assign sum        = {1'b0, last_past_q} + {1'b0, range_length_i};

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    issue_cnt_d = issue_cnt_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_last_d  = cmp_last_q;
    last_past_d = last_past_q;
    query_d     = query_q;
    res_found_d = res_found_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    row_d       = row_q;
    col_d       = col_q;
    full_d      = full_q;
    rd_addr     = issue_cnt_q[AddrW-1:0];
    mem_ctrl    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      brpt_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          row_d       = '0;
          col_d       = '0;
          full_d      = 1'b0;
          case (brpt_pkg::brpt_func_e'(func_i))
            brpt_pkg::FUNC_ADD: begin
              if (tbl_full) begin
                full_d = 1'b1;
              end else begin
                mem_ctrl.wr_en         = 1'b1;
                mem_ctrl.wr_data.first = range_start_i;
                mem_ctrl.wr_data.past  = range_end_i;
                mem_ctrl.wr_data.row   = source_row_i;
                mem_ctrl.wr_data.col   = source_column_i;
                fill_d                 = fill_q + 1'b1;
                last_past_d            = range_end_i;
              end
            end
            brpt_pkg::FUNC_ADD_AFTER: begin
              if (tbl_full) begin
                full_d = 1'b1;
              end else begin
                mem_ctrl.wr_en         = 1'b1;
                mem_ctrl.wr_data.first = last_past_q;
                mem_ctrl.wr_data.past  = sum[OfsW] ? '1 : sum[OfsW-1:0];
                mem_ctrl.wr_data.row   = source_row_i;
                mem_ctrl.wr_data.col   = source_column_i;
                fill_d                 = fill_q + 1'b1;
                last_past_d            = mem_ctrl.wr_data.past;
              end
            end
            brpt_pkg::FUNC_LOOKUP: begin
              if (fill_q != '0) begin
                out_valid_d    = 1'b0;
                mem_ctrl.rd_en = 1'b1;
                rd_addr        = '0;
                issue_cnt_d    = CntW'(1);
                cmp_vld_d      = 1'b1;
                cmp_last_d     = (fill_q == CntW'(1));
                query_d        = query_offset_i;
                state_d        = brpt_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      brpt_pkg::ST_SCAN: begin
        if (issue_cnt_q < fill_q) begin
          mem_ctrl.rd_en = 1'b1;
          issue_cnt_d    = issue_cnt_q + 1'b1;
          cmp_vld_d      = 1'b1;
          cmp_last_d     = (issue_cnt_q == fill_q - 1'b1);
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q && hit) begin
          res_found_d = 1'b1;
          res_row_d   = rd_data.row;
          res_col_d   = rd_data.col;
          cmp_vld_d   = 1'b0;
          state_d     = brpt_pkg::ST_DONE;
        end else if (cmp_vld_q && cmp_last_q) begin
          res_found_d = 1'b0;
          res_row_d   = '0;
          res_col_d   = '0;
          cmp_vld_d   = 1'b0;
          state_d     = brpt_pkg::ST_DONE;
        end
      end
      brpt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          row_d       = res_row_q;
          col_d       = res_col_q;
          full_d      = 1'b0;
          state_d     = brpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = brpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brpt_pkg::ST_IDLE;
      fill_q      <= '0;
      issue_cnt_q <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_last_q  <= 1'b0;
      last_past_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_cnt_q <= issue_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_last_q  <= cmp_last_d;
      last_past_q <= last_past_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q     <= query_d;
    res_found_q <= res_found_d;
    res_row_q   <= res_row_d;
    res_col_q   <= res_col_d;
    found_q     <= found_d;
    row_q       <= row_d;
    col_q       <= col_d;
    full_q      <= full_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign found_row_o    = row_q;
  assign found_column_o = col_q;
  assign table_full_o   = full_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count above table depth");

  a_fill_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ($past(accept) && (fill_q == $past(fill_q) + 1'b1)))
    else $error("fill count moved without an accepted add");

  a_scan_compares: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brpt_pkg::ST_SCAN) |-> cmp_vld_q)
    else $error("scan state without a pending compare");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (row_q == '0 && col_q == '0))
    else $error("miss result carries a position");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && full_q) |-> !found_q)
    else $error("dropped add reports a match");

endmodule

FILE: rtl/core/brpt_entry_mem.sv
// Entry store of the byte range position table: one write port, one read port.
// Read data is registered and appears in the cycle after the read request.
// Depends on brpt_pkg.
module brpt_entry_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                   clk_i,
  input  brpt_pkg::brpt_mem_ctrl_t ctrl_i,
  input  logic [AddrW-1:0]       wr_addr_i,
  input  logic [AddrW-1:0]       rd_addr_i,
  output brpt_pkg::brpt_entry_t  rd_data_o
);

  brpt_pkg::brpt_entry_t mem_q [Depth];
  brpt_pkg::brpt_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= ctrl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
